[hdl/fisa_pkg.sv]
`default_nettype none

package fisa_pkg;

  localparam int SLOT_W   = 10;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;

  // capacity after reset, held to DEPTH when DEPTH is smaller
  localparam int CAP_RESET = 1024;

  typedef enum logic {
    FUNC_ALLOC   = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic              func;
    logic [SLOT_W-1:0] slot_in;
  } in_t;

  typedef struct packed {
    logic [SLOT_W-1:0]   slot_out;
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  free_count;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;  // request transfer this cycle
    logic load;    // move staged result into the output register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

[hdl/fisa_ram.sv]
`default_nettype none

module fisa_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[hdl/fisa_ctrl.sv]
`default_nettype none

module fisa_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output fisa_pkg::ctrl_cmd_t       cmd
);

  typedef enum logic {
    S_IDLE,
    S_PEND   // result staged, waiting for the output register
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  always_comb begin
    out_free   = !out_valid_r || out_ready;
    cmd.load   = (state_r == S_PEND) && out_free;
    in_ready   = (state_r == S_IDLE) || cmd.load;
    cmd.accept = in_valid && in_ready;

    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept) state_nxt = S_PEND;
      end
      S_PEND: begin
        if (cmd.accept)    state_nxt = S_PEND;
        else if (cmd.load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase

    if (cmd.load)       out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
    else                out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_accept_stages: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept |=> state_r == S_PEND)
    else $error("accepted request not staged");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_valid_r)
    else $error("loaded result not presented");

  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r)
    else $error("result dropped before transfer");

endmodule

`default_nettype wire

[hdl/fisa_dp.sv]
`default_nettype none

module fisa_dp #(
  parameter int DEPTH = 1024
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire fisa_pkg::ctrl_cmd_t                  cmd,
  input  wire fisa_pkg::in_t                        in_data,
  input  wire logic                                 cfg_we,
  input  wire logic [fisa_pkg::COUNT_W-1:0]         cfg_wdata,
  output fisa_pkg::out_t                            out_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] CAP_RST =
    CW'((DEPTH < fisa_pkg::CAP_RESET) ? DEPTH : fisa_pkg::CAP_RESET);

  // cap: slots managed; ft: free total (stack pointer);
  // lw: low-water mark of ft since refill. Entries below lw still hold
  // their refill value cap-1-i and are never read from the RAM.
  logic [CW-1:0] cap_r, cap_nxt;
  logic [CW-1:0] ft_r, ft_nxt;
  logic [CW-1:0] lw_r, lw_nxt;

  logic [CW-1:0] ft_dec, cfg_cap, fresh_full;
  logic          is_alloc, alloc_ok, rel_ok;

  // staged result
  logic [fisa_pkg::STATUS_W-1:0] st_status_r;
  logic [fisa_pkg::COUNT_W-1:0]  st_count_r;
  logic [fisa_pkg::SLOT_W-1:0]   st_fresh_r;
  logic                          st_ram_r;

  logic [fisa_pkg::SLOT_W-1:0]   ram_q;
  fisa_pkg::out_t                out_data_r;

  always_comb begin
    ft_dec     = ft_r - CW'(1);
    fresh_full = cap_r - ft_r;  // cap-1-(ft-1)
    is_alloc   = in_data.func == fisa_pkg::FUNC_ALLOC;
    alloc_ok   = is_alloc && (ft_r != '0);
    rel_ok     = !is_alloc && (ft_r < cap_r);
    cfg_cap    = (32'(cfg_wdata) > 32'(DEPTH)) ? CW'(DEPTH) : CW'(cfg_wdata);

    cap_nxt = cap_r;
    ft_nxt  = ft_r;
    lw_nxt  = lw_r;
    if (cfg_we && (cfg_wdata != '0)) begin
      cap_nxt = cfg_cap;
      ft_nxt  = cfg_cap;
      lw_nxt  = cfg_cap;
    end else if (cmd.accept) begin
      if (alloc_ok) begin
        ft_nxt = ft_dec;
        if (ft_r == lw_r) lw_nxt = ft_dec;
      end else if (rel_ok) begin
        ft_nxt = ft_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RST;
      ft_r  <= CAP_RST;
      lw_r  <= CAP_RST;
    end else begin
      cap_r <= cap_nxt;
      ft_r  <= ft_nxt;
      lw_r  <= lw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      st_ram_r <= alloc_ok && (ft_dec >= lw_r);
      st_fresh_r <= alloc_ok ? fisa_pkg::SLOT_W'(fresh_full) : '0;
      if (is_alloc) begin
        st_status_r <= alloc_ok ? fisa_pkg::ST_OK : fisa_pkg::ST_EMPTY;
      end else begin
        st_status_r <= rel_ok ? fisa_pkg::ST_OK : fisa_pkg::ST_FULL;
      end
      st_count_r <= fisa_pkg::COUNT_W'(ft_nxt);
    end
    if (cmd.load) begin
      out_data_r.slot_out   <= st_ram_r ? ram_q : st_fresh_r;
      out_data_r.status     <= st_status_r;
      out_data_r.free_count <= st_count_r;
    end
  end

  fisa_ram #(
    .WIDTH (fisa_pkg::SLOT_W),
    .DEPTH (DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.accept && rel_ok),
    .waddr (ft_r[AW-1:0]),
    .wdata (in_data.slot_in),
    .re    (cmd.accept && alloc_ok),
    .raddr (ft_dec[AW-1:0]),
    .rdata (ram_q)
  );

  assign out_data = out_data_r;

  a_ft_le_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ft_r <= cap_r)
    else $error("free total above capacity");

  a_lw_le_ft: assert property (@(posedge clk) disable iff (!rst_n)
    lw_r <= ft_r)
    else $error("low-water mark above free total");

  a_empty_holds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.accept && is_alloc && (ft_r == '0) && !cfg_we |=> ft_r == '0)
    else $error("failed allocate changed the stack");

endmodule

`default_nettype wire

[hdl/free_index_stack_allocator.sv]
`default_nettype none

// Free-slot allocator: a stack of free indices in one RAM (DEPTH x 10 bits,
// one write port, one registered read port). Allocate pops the top index,
// release pushes the given index back; each request gives exactly one
// result (slot, status, free count), staged with the registered RAM read
// as the request transfers and loaded when the output register is free;
// one request per cycle is sustained while out_ready keeps up. The output
// register decouples the sides, so a new request can transfer while the
// previous result is still waiting. After reset, and after each nonzero
// write to cfg_wdata (capacity, saturated to DEPTH), the stack reads as if
// refilled with capacity-1 down to 0 with no clearing pass: a low-water
// mark tracks which entries still hold their refill value. A capacity
// write of zero is ignored. Write capacity only while no request is in
// flight. Releases are not checked for duplicates; a release with every
// slot free reports full, an allocate with none free reports empty.
module free_index_stack_allocator #(
  parameter int DEPTH = 1024
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire fisa_pkg::in_t                 in_data,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output fisa_pkg::out_t                     out_data,
  input  wire logic                          cfg_we,
  input  wire logic [fisa_pkg::COUNT_W-1:0]  cfg_wdata
);

  fisa_pkg::ctrl_cmd_t cmd;

  // handshake and staging control
  fisa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // stack pointer, refill tracking and result path
  fisa_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
